// ===== sv/pkfq_pkg.sv =====
// Shared types and codes for the packet FIFO with length queue.
package pkfq_pkg;

	localparam int FIELD_W = 11;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic       op;
		logic [7:0] push_byte;
		logic       push_last;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         pop_byte;
		logic               pop_last;
		logic [FIELD_W-1:0] packet_length;
		logic [FIELD_W-1:0] bytes_stored;
		logic [FIELD_W-1:0] packets_stored;
	} out_t;

endpackage

// ===== sv/pkfq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
module pkfq_ram #(
	parameter int W = 8,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/packet_fifo_with_length_queue_unit.sv =====
// Packet FIFO: a byte ring and a ring of packet lengths, one push or pop per transaction.
// A push is accepted while busy is low and its result appears on the result port in the next
// cycle, marked by done; busy stays low, so a push transaction can follow every cycle.
// A pop needs one read of the byte and length memories: busy rises when the pop is accepted
// and stays high for a single cycle while the memories are read; the result is then shown
// with done, and the next transaction can be taken once busy is low again. The receiver
// cannot stall: every result is valid for exactly the one cycle that done is high. Both
// memories need no clearing after reset; only entries already written are ever read.
module packet_fifo_with_length_queue_unit #(
	parameter int DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pkfq_pkg::in_t     req,
	output logic              done,
	output pkfq_pkg::out_t    result
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [PW-1:0] wr_ptr_q, rd_ptr_q, lwr_ptr_q, lrd_ptr_q;
	logic [CW-1:0] byte_cnt_q, pkt_cnt_q, open_len_q, left_q;
	logic          busy_q, done_q;
	pkfq_pkg::out_t result_q;

	logic [PW-1:0] wr_ptr_d, rd_ptr_d, lwr_ptr_d, lrd_ptr_d;
	logic [CW-1:0] byte_cnt_d, pkt_cnt_d, open_len_d, left_d, len_sel, open_len_inc;
	logic          accept, push_we, len_we, fire;
	logic [7:0]    byte_rdata;
	logic [CW-1:0] len_rdata;
	pkfq_pkg::out_t result_d;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign accept       = start && !busy_q;
	assign open_len_inc = open_len_q + CW'(1);
	assign push_we      = accept && (req.op == pkfq_pkg::OP_PUSH) &&
	                      (byte_cnt_q != CW'(DEPTH));
	assign len_we       = push_we && req.push_last;

	pkfq_ram #(.W(8), .D(DEPTH)) u_byte_ram (
		.clk   (clk),
		.we    (push_we),
		.waddr (wr_ptr_q),
		.wdata (req.push_byte),
		.raddr (rd_ptr_q),
		.rdata (byte_rdata)
	);

	pkfq_ram #(.W(CW), .D(DEPTH)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (lwr_ptr_q),
		.wdata (open_len_inc),
		.raddr (lrd_ptr_q),
		.rdata (len_rdata)
	);

	always_comb begin
		wr_ptr_d   = wr_ptr_q;
		rd_ptr_d   = rd_ptr_q;
		lwr_ptr_d  = lwr_ptr_q;
		lrd_ptr_d  = lrd_ptr_q;
		byte_cnt_d = byte_cnt_q;
		pkt_cnt_d  = pkt_cnt_q;
		open_len_d = open_len_q;
		left_d     = left_q;
		len_sel    = (left_q == '0) ? len_rdata : left_q;
		fire       = 1'b0;
		result_d   = '0;
		result_d.status = pkfq_pkg::ST_DONE;

		if (busy_q) begin
			// pop: memory data for the current pointers is now valid
			fire = 1'b1;
			if (left_q == '0 && pkt_cnt_q == '0) begin
				result_d.status = pkfq_pkg::ST_EMPTY;
			end else begin
				left_d   = len_sel - CW'(1);
				rd_ptr_d = ring_next(rd_ptr_q);
				if (byte_cnt_q != '0) begin
					byte_cnt_d = byte_cnt_q - CW'(1);
				end
				result_d.pop_byte      = byte_rdata;
				result_d.packet_length = pkfq_pkg::FIELD_W'(len_rdata);
				if (left_d == '0) begin
					result_d.pop_last = 1'b1;
					lrd_ptr_d         = ring_next(lrd_ptr_q);
					if (pkt_cnt_q != '0) begin
						pkt_cnt_d = pkt_cnt_q - CW'(1);
					end
				end
			end
		end else if (accept && req.op == pkfq_pkg::OP_PUSH) begin
			fire = 1'b1;
			if (!push_we) begin
				result_d.status = pkfq_pkg::ST_FULL;
			end else begin
				wr_ptr_d   = ring_next(wr_ptr_q);
				byte_cnt_d = byte_cnt_q + CW'(1);
				open_len_d = open_len_inc;
				if (req.push_last) begin
					lwr_ptr_d  = ring_next(lwr_ptr_q);
					pkt_cnt_d  = pkt_cnt_q + CW'(1);
					open_len_d = '0;
				end
			end
		end

		result_d.bytes_stored   = pkfq_pkg::FIELD_W'(byte_cnt_d);
		result_d.packets_stored = pkfq_pkg::FIELD_W'(pkt_cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			lwr_ptr_q  <= '0;
			lrd_ptr_q  <= '0;
			byte_cnt_q <= '0;
			pkt_cnt_q  <= '0;
			open_len_q <= '0;
			left_q     <= '0;
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			wr_ptr_q   <= wr_ptr_d;
			rd_ptr_q   <= rd_ptr_d;
			lwr_ptr_q  <= lwr_ptr_d;
			lrd_ptr_q  <= lrd_ptr_d;
			byte_cnt_q <= byte_cnt_d;
			pkt_cnt_q  <= pkt_cnt_d;
			open_len_q <= open_len_d;
			left_q     <= left_d;
			busy_q     <= accept && (req.op == pkfq_pkg::OP_POP);
			done_q     <= fire;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== test/packet_fifo_with_length_queue_checker.sv =====
`timescale 1ns / 1ps
// Checker for the packet FIFO: tracks FIFO contents and compares every result transaction.
module packet_fifo_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  pkfq_pkg::in_t  req,
	input  logic           done,
	input  pkfq_pkg::out_t result,
	output int             errors,
	output int             pending
);

	localparam int RING_DEPTH = 1024;
	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int MAX_PRINTED = 60;

	logic [7:0]                   byte_ring [RING_DEPTH];
	logic [pkfq_pkg::FIELD_W-1:0] len_ring [RING_DEPTH];
	logic [PTR_W-1:0]             byte_wr, byte_rd, len_wr, len_rd;
	logic [pkfq_pkg::FIELD_W-1:0] bytes_held, pkts_held, open_len, left_in_pkt;
	pkfq_pkg::out_t               results_due[$];
	pkfq_pkg::out_t               oldest;
	int                           n_results;

	task automatic report_mismatch(input string msg);
		if (errors < MAX_PRINTED)
			$display("%0t: transaction %0d: %s", $realtime, n_results, msg);
		errors++;
	endtask

	// Advances the FIFO contents by one transaction and returns the result it gives.
	function automatic pkfq_pkg::out_t step_packet_fifo(input pkfq_pkg::in_t t);
		pkfq_pkg::out_t               r;
		logic [pkfq_pkg::FIELD_W-1:0] head_len;
		r = '0;
		r.status = pkfq_pkg::ST_DONE;
		if (t.op == pkfq_pkg::OP_PUSH) begin
			if (bytes_held >= RING_DEPTH) begin
				r.status = pkfq_pkg::ST_FULL;
			end else begin
				byte_ring[byte_wr] = t.push_byte;
				byte_wr = byte_wr + 1'b1;
				bytes_held = bytes_held + 1'b1;
				open_len = open_len + 1'b1;
				if (t.push_last) begin
					len_ring[len_wr] = open_len;
					len_wr = len_wr + 1'b1;
					pkts_held = pkts_held + 1'b1;
					open_len = '0;
				end
			end
		end else if (left_in_pkt == 0 && pkts_held == 0) begin
			r.status = pkfq_pkg::ST_EMPTY;
		end else begin
			head_len = len_ring[len_rd];
			if (left_in_pkt == 0)
				left_in_pkt = head_len;
			r.packet_length = head_len;
			r.pop_byte = byte_ring[byte_rd];
			byte_rd = byte_rd + 1'b1;
			if (bytes_held > 0)
				bytes_held = bytes_held - 1'b1;
			left_in_pkt = left_in_pkt - 1'b1;
			if (left_in_pkt == 0) begin
				r.pop_last = 1'b1;
				len_rd = len_rd + 1'b1;
				if (pkts_held > 0)
					pkts_held = pkts_held - 1'b1;
			end
		end
		r.bytes_stored = bytes_held;
		r.packets_stored = pkts_held;
		return r;
	endfunction

	task automatic compare_result(input pkfq_pkg::out_t got, input pkfq_pkg::out_t want);
		if (got.status !== want.status)
			report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
		if (got.pop_byte !== want.pop_byte)
			report_mismatch($sformatf("pop_byte %h, expected %h", got.pop_byte, want.pop_byte));
		if (got.pop_last !== want.pop_last)
			report_mismatch($sformatf("pop_last %b, expected %b", got.pop_last, want.pop_last));
		if (got.packet_length !== want.packet_length)
			report_mismatch($sformatf("packet_length %0d, expected %0d",
				got.packet_length, want.packet_length));
		if (got.bytes_stored !== want.bytes_stored)
			report_mismatch($sformatf("bytes_stored %0d, expected %0d",
				got.bytes_stored, want.bytes_stored));
		if (got.packets_stored !== want.packets_stored)
			report_mismatch($sformatf("packets_stored %0d, expected %0d",
				got.packets_stored, want.packets_stored));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_wr = '0;
			byte_rd = '0;
			len_wr = '0;
			len_rd = '0;
			bytes_held = '0;
			pkts_held = '0;
			open_len = '0;
			left_in_pkt = '0;
			n_results = 0;
			results_due.delete();
			pending <= 0;
		end else begin
			// results belong to earlier transactions, so check before predicting
			if (done) begin
				if (results_due.size() == 0) begin
					report_mismatch("result with no transaction outstanding");
				end else begin
					oldest = results_due.pop_front();
					compare_result(result, oldest);
				end
				n_results++;
			end
			if (start && !busy)
				results_due.push_back(step_packet_fifo(req));
			pending <= results_due.size();
		end
	end

endmodule

// ===== test/packet_fifo_with_length_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the packet FIFO: stimulus, watchdog and final verdict.
module packet_fifo_with_length_queue_unit_tb;

	localparam int STALL_LIMIT = 1000;
	localparam int BURST_ITEMS = 130;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	pkfq_pkg::in_t  req = '0;
	logic           busy, done;
	pkfq_pkg::out_t result;
	int             errors, pending;
	int             idle_pct = 16;
	int             full_refusals = 0;
	int             empty_pops = 0;
	int             quiet_cycles = 0;

	always #5 clk = ~clk;

	packet_fifo_with_length_queue_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .result(result)
	);

	packet_fifo_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		if (done && result.status == pkfq_pkg::ST_FULL)
			full_refusals <= full_refusals + 1;
		if (done && result.status == pkfq_pkg::ST_EMPTY)
			empty_pops <= empty_pops + 1;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Holds one transaction on the request port until it is taken.
	task automatic send_item(input logic kind, input logic [7:0] data, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= pkfq_pkg::in_t'{kind, data, last};
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly whole packets followed by some pops, with odd stray transactions mixed in.
	task automatic random_bursts(input int n_items);
		int sent;
		int pkt_len;
		int n_pops;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(4) == 0) begin
				send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
				sent++;
			end else begin
				pkt_len = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(6, 1);
				for (int i = 0; i < pkt_len; i++)
					send_item(pkfq_pkg::OP_PUSH, 8'($urandom_range(255)), i == pkt_len - 1);
				n_pops = $urandom_range(pkt_len + 2);
				for (int i = 0; i < n_pops; i++)
					send_item(pkfq_pkg::OP_POP, 8'($urandom_range(255)),
						1'($urandom_range(1)));
				sent += pkt_len + n_pops;
			end
		end
	endtask

	initial begin
		int base;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(pkfq_pkg::OP_POP, 8'h00, 1'b0);
		send_item(pkfq_pkg::OP_PUSH, 8'h00, 1'b1);
		send_item(pkfq_pkg::OP_PUSH, 8'hFF, 1'b0);
		send_item(pkfq_pkg::OP_PUSH, 8'hA5, 1'b1);
		send_item(pkfq_pkg::OP_POP, 8'h00, 1'b0);
		send_item(pkfq_pkg::OP_POP, 8'h00, 1'b0);
		send_item(pkfq_pkg::OP_PUSH, 8'h5A, 1'b0);
		send_item(pkfq_pkg::OP_POP, 8'h00, 1'b0);
		// only an unfinished packet is held here
		send_item(pkfq_pkg::OP_POP, 8'h00, 1'b0);
		send_item(pkfq_pkg::OP_PUSH, 8'h81, 1'b1);
		send_item(pkfq_pkg::OP_POP, 8'hFF, 1'b1);
		send_item(pkfq_pkg::OP_POP, 8'h00, 1'b0);
		send_item(pkfq_pkg::OP_POP, 8'hFF, 1'b1);
		wait_all_results();

		random_bursts(BURST_ITEMS);
		wait_all_results();
		idle_pct = 49;
		random_bursts(BURST_ITEMS);
		wait_all_results();
		idle_pct = 0;
		random_bursts(BURST_ITEMS);

		// drain every complete packet
		base = empty_pops;
		while (empty_pops == base)
			send_item(pkfq_pkg::OP_POP, 8'($urandom_range(255)), 1'($urandom_range(1)));

		// fill the store with a single unfinished packet: it stays wedged from here on
		base = full_refusals;
		while (full_refusals < base + 3)
			send_item(pkfq_pkg::OP_PUSH, 8'($urandom_range(255)), 1'b0);
		send_item(pkfq_pkg::OP_PUSH, 8'hFF, 1'b1);
		send_item(pkfq_pkg::OP_POP, 8'h00, 1'b0);
		send_item(pkfq_pkg::OP_PUSH, 8'h00, 1'b1);
		send_item(pkfq_pkg::OP_POP, 8'hFF, 1'b1);

		wait_all_results();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
